// File: sv/pnct_pkg.sv
// pnct_pkg: shared types, codes and helper functions for the palette nearest color table
// no dependencies; used by every file of the block
`default_nettype none

package pnct_pkg;

  localparam int ENTRIES_DEFAULT = 256;
  localparam int COLOR_W         = 24;
  localparam int INDEX_W         = 8;
  localparam int COUNT_W         = 9;
  localparam int SIZE_W          = 4;
  localparam int DIST_W          = 18;

  localparam logic [COUNT_W-1:0] MIN_SIZE_COUNT = COUNT_W'(4);
  localparam logic [SIZE_W-1:0]  MIN_SIZE_LOG2  = SIZE_W'(2);

  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_TRANSPARENT = 2'd1,
    OP_LOOKUP      = 2'd2
  } pnct_op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COLOR_W-1:0] color;
  } pnct_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
    logic [COUNT_W-1:0] color_count;
    logic [SIZE_W-1:0]  size_log2;
    logic               dropped;
  } pnct_out_t;

  // item travelling down the cell row
  typedef struct packed {
    logic               valid;
    logic               lookup;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               tvalid;
    logic [INDEX_W-1:0] tslot;
    logic               found;
    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_idx;
    logic [SIZE_W-1:0]  size_log2;
    logic               dropped;
  } pnct_tok_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] slot;
    logic [COLOR_W-1:0] color;
  } pnct_wr_t;

  function automatic logic [15:0] chan_sq(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  function automatic logic [DIST_W-1:0] rgb_dist(logic [COLOR_W-1:0] p, logic [COLOR_W-1:0] q);
    return DIST_W'(chan_sq(p[23:16], q[23:16])) + DIST_W'(chan_sq(p[15:8], q[15:8]))
         + DIST_W'(chan_sq(p[7:0], q[7:0]));
  endfunction

  // 2 below four entries, otherwise ceil(log2(cnt))
  function automatic logic [SIZE_W-1:0] size_log2_f(logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] m;
    logic [SIZE_W-1:0]  k;
    m = cnt - COUNT_W'(1);
    k = MIN_SIZE_LOG2;
    for (int b = 0; b < COUNT_W; b++) begin
      if (m[b]) k = SIZE_W'(b + 1);
    end
    if (cnt < MIN_SIZE_COUNT) k = MIN_SIZE_LOG2;
    return k;
  endfunction

endpackage

`default_nettype wire

// File: sv/pnct_front.sv
// pnct_front: entry stage, keeps entry count and transparent slot, issues cell writes
// depends on pnct_pkg
`default_nettype none

module pnct_front #(
  parameter int ENTRIES = pnct_pkg::ENTRIES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               accept,
  input  wire pnct_pkg::pnct_in_t in_data,
  output pnct_pkg::pnct_wr_t      wr,
  output pnct_pkg::pnct_tok_t     tok_out
);

  localparam logic [pnct_pkg::COUNT_W-1:0] FULL = pnct_pkg::COUNT_W'(ENTRIES);

  logic [pnct_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         tvalid_r, tvalid_nxt;
  logic [pnct_pkg::INDEX_W-1:0] tslot_r, tslot_nxt;
  pnct_pkg::pnct_tok_t          tok_r, tok_nxt;
  logic                         has_room;
  logic                         dropped;

  assign has_room = (count_r < FULL);

  always_comb begin
    count_nxt  = count_r;
    tvalid_nxt = tvalid_r;
    tslot_nxt  = tslot_r;
    dropped    = 1'b0;
    wr.en      = 1'b0;
    wr.slot    = count_r[pnct_pkg::INDEX_W-1:0];
    wr.color   = in_data.color;
    if (accept) begin
      case (in_data.operation)
        pnct_pkg::OP_APPEND: begin
          if (has_room) begin
            wr.en     = 1'b1;
            count_nxt = count_r + pnct_pkg::COUNT_W'(1);
          end else begin
            dropped = 1'b1;
          end
        end
        pnct_pkg::OP_TRANSPARENT: begin
          if (!tvalid_r) begin
            if (has_room) begin
              wr.en      = 1'b1;
              wr.color   = '0;
              count_nxt  = count_r + pnct_pkg::COUNT_W'(1);
              tvalid_nxt = 1'b1;
              tslot_nxt  = count_r[pnct_pkg::INDEX_W-1:0];
            end else begin
              dropped = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    if (adv) begin
      tok_nxt.valid     = accept;
      tok_nxt.lookup    = (in_data.operation == pnct_pkg::OP_LOOKUP);
      tok_nxt.color     = in_data.color;
      tok_nxt.count     = count_nxt;
      tok_nxt.tvalid    = tvalid_nxt;
      tok_nxt.tslot     = tslot_nxt;
      tok_nxt.found     = 1'b0;
      tok_nxt.best_dist = '0;
      tok_nxt.best_idx  = '0;
      tok_nxt.size_log2 = pnct_pkg::size_log2_f(count_nxt);
      tok_nxt.dropped   = dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tvalid_r    <= 1'b0;
      tslot_r     <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      tvalid_r    <= tvalid_nxt;
      tslot_r     <= tslot_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.lookup    <= tok_nxt.lookup;
    tok_r.color     <= tok_nxt.color;
    tok_r.count     <= tok_nxt.count;
    tok_r.tvalid    <= tok_nxt.tvalid;
    tok_r.tslot     <= tok_nxt.tslot;
    tok_r.found     <= tok_nxt.found;
    tok_r.best_dist <= tok_nxt.best_dist;
    tok_r.best_idx  <= tok_nxt.best_idx;
    tok_r.size_log2 <= tok_nxt.size_log2;
    tok_r.dropped   <= tok_nxt.dropped;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: sv/pnct_cell.sv
// pnct_cell: one palette slot; holds its color and updates the passing best match
// depends on pnct_pkg
`default_nettype none

module pnct_cell #(
  parameter int SLOT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire pnct_pkg::pnct_wr_t  wr,
  input  wire pnct_pkg::pnct_tok_t tok_in,
  output pnct_pkg::pnct_tok_t      tok_out
);

  localparam logic [pnct_pkg::COUNT_W-1:0] SLOT_C = pnct_pkg::COUNT_W'(SLOT);
  localparam logic [pnct_pkg::INDEX_W-1:0] SLOT_I = pnct_pkg::INDEX_W'(SLOT);

  logic [pnct_pkg::COLOR_W-1:0] color_r;
  pnct_pkg::pnct_tok_t          tok_r, tok_nxt;
  logic [pnct_pkg::DIST_W-1:0]  cur_dist;
  logic                         eligible;

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == SLOT_I) begin
      color_r <= wr.color;
    end
  end

  assign cur_dist = pnct_pkg::rgb_dist(color_r, tok_in.color);
  assign eligible = tok_in.lookup && (SLOT_C < tok_in.count)
                  && !(tok_in.tvalid && tok_in.tslot == SLOT_I);

  always_comb begin
    tok_nxt = tok_in;
    if (eligible && (!tok_in.found || cur_dist < tok_in.best_dist)) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_dist = cur_dist;
      tok_nxt.best_idx  = SLOT_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r.valid <= tok_nxt.valid;
    end
    if (adv) begin
      tok_r.lookup    <= tok_nxt.lookup;
      tok_r.color     <= tok_nxt.color;
      tok_r.count     <= tok_nxt.count;
      tok_r.tvalid    <= tok_nxt.tvalid;
      tok_r.tslot     <= tok_nxt.tslot;
      tok_r.found     <= tok_nxt.found;
      tok_r.best_dist <= tok_nxt.best_dist;
      tok_r.best_idx  <= tok_nxt.best_idx;
      tok_r.size_log2 <= tok_nxt.size_log2;
      tok_r.dropped   <= tok_nxt.dropped;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: sv/palette_nearest_color_table_unit.sv
// palette_nearest_color_table_unit: top level, entry stage followed by a row of palette cells
// depends on pnct_pkg, pnct_front, pnct_cell
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one command beat: append a color,
//   mark transparency (appends black once), or look up the nearest palette slot.
//   out channel (out_valid/out_ready/out_data) returns one result beat per command,
//   in command order: nearest slot, entry count, table size exponent, drop flag.
//   each palette slot lives in its own cell; a beat walks the row one cell per
//   cycle while the row advances and carries the count and transparent slot seen
//   when it was taken, so appends that follow it never disturb its search.
//   a beat passes the entry stage register and then every cell register of the
//   row before out_valid rises.
//   throughput: one beat per cycle while out_ready is high; the row moves as a
//   whole and a new beat can enter in every cycle that it moves.
//   when the receiver stalls (out_valid high, out_ready low) the whole row holds
//   and in_ready drops; no beat is lost and the shown result stays put.
//   reset (rst_n low, synchronous) empties the table, clears transparency and
//   drops all beats in flight; palette contents are not cleared, only slots below
//   the entry count are ever searched.
`default_nettype none

module palette_nearest_color_table_unit #(
  parameter int ENTRIES = pnct_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pnct_pkg::pnct_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pnct_pkg::pnct_out_t      out_data
);

  pnct_pkg::pnct_tok_t tok [ENTRIES+1];
  pnct_pkg::pnct_wr_t  wr;
  logic                adv;
  logic                accept;

  assign adv      = !tok[ENTRIES].valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  pnct_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .accept  (accept),
    .in_data (in_data),
    .wr      (wr),
    .tok_out (tok[0])
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pnct_cell #(
      .SLOT (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign out_valid              = tok[ENTRIES].valid;
  assign out_data.nearest_index = tok[ENTRIES].best_idx;
  assign out_data.color_count   = tok[ENTRIES].count;
  assign out_data.size_log2     = tok[ENTRIES].size_log2;
  assign out_data.dropped       = tok[ENTRIES].dropped;

endmodule

`default_nettype wire

// File: sv/pnct_checker.sv
// pnct_checker: port-level assertions for the palette nearest color table, plus its bind
// depends on pnct_pkg and palette_nearest_color_table_unit
`default_nettype none

module pnct_checker #(
  parameter int ENTRIES = pnct_pkg::ENTRIES_DEFAULT
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire pnct_pkg::pnct_in_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire pnct_pkg::pnct_out_t out_data
);

  localparam logic [pnct_pkg::COUNT_W-1:0] FULL = pnct_pkg::COUNT_W'(ENTRIES);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // reset flushes the row
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // count never exceeds the table and index stays inside it
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.color_count <= FULL
      && (out_data.nearest_index == '0
          || pnct_pkg::COUNT_W'(out_data.nearest_index) < out_data.color_count))
    else $error("count or index out of range");

  // size exponent follows the count
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.size_log2 == pnct_pkg::size_log2_f(out_data.color_count))
    else $error("size exponent mismatch");

  // ready only drops while a result is shown and stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

endmodule

bind palette_nearest_color_table_unit pnct_checker #(
  .ENTRIES (ENTRIES)
) u_pnct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb.sv
// tb: self-checking bench for palette_nearest_color_table_unit, random bursts and stalls
// predicts each result beat from its own palette copy and checks it in order
// depends on pnct_pkg and palette_nearest_color_table_unit
`timescale 1ns / 100ps

module tb;
  import pnct_pkg::*;

  localparam int PAL_DEPTH = ENTRIES_DEFAULT;
  localparam int RANDOM_BEATS = 1730;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 900;
  localparam int HOLD_AFTER = 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class palette_scoreboard;
    logic [COLOR_W-1:0] colors [ENTRIES_DEFAULT];
    logic [COUNT_W-1:0] used;
    logic               tvalid;
    logic [INDEX_W-1:0] tslot;
    pnct_out_t          due_q[$];
    int unsigned        failures;
    int unsigned        checked;

    function new();
      used = '0;
      tvalid = 1'b0;
      tslot = '0;
      failures = 0;
      checked = 0;
    endfunction

    function logic [SIZE_W-1:0] size_exp(logic [COUNT_W-1:0] n);
      logic [SIZE_W-1:0] k;
      k = MIN_SIZE_LOG2;
      if (n >= MIN_SIZE_COUNT) begin
        while ((1 << k) < int'(n)) k++;
      end
      return k;
    endfunction

    function logic [DIST_W-1:0] sq_dist(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int dr, dg, db;
      dr = int'(a[23:16]) - int'(b[23:16]);
      dg = int'(a[15:8]) - int'(b[15:8]);
      db = int'(a[7:0]) - int'(b[7:0]);
      return DIST_W'(dr * dr + dg * dg + db * db);
    endfunction

    function logic [INDEX_W-1:0] nearest_slot(logic [COLOR_W-1:0] rgb);
      logic [INDEX_W-1:0] best;
      logic [DIST_W-1:0]  best_d;
      logic [DIST_W-1:0]  d;
      bit                 found;
      best = '0;
      best_d = '0;
      found = 1'b0;
      for (int i = 0; i < int'(used); i++) begin
        if (tvalid && i == int'(tslot)) continue;
        d = sq_dist(colors[i], rgb);
        if (!found || d < best_d) begin
          found = 1'b1;
          best = INDEX_W'(i);
          best_d = d;
        end
      end
      return best;
    endfunction

    function void note_input(pnct_in_t beat);
      pnct_out_t r;
      r = '0;
      case (beat.operation)
        OP_APPEND: begin
          if (int'(used) < ENTRIES_DEFAULT) begin
            colors[used[INDEX_W-1:0]] = beat.color;
            used++;
          end else begin
            r.dropped = 1'b1;
          end
        end
        OP_TRANSPARENT: begin
          if (!tvalid) begin
            if (int'(used) < ENTRIES_DEFAULT) begin
              colors[used[INDEX_W-1:0]] = '0;
              tslot = used[INDEX_W-1:0];
              tvalid = 1'b1;
              used++;
            end else begin
              r.dropped = 1'b1;
            end
          end
        end
        OP_LOOKUP: r.nearest_index = nearest_slot(beat.color);
        default: ;
      endcase
      r.color_count = used;
      r.size_log2 = size_exp(used);
      due_q.push_back(r);
    endfunction

    function void check_result(pnct_out_t got);
      pnct_out_t want;
      if (due_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result beat: idx %0d count %0d size %0d drop %0b",
                   got.nearest_index, got.color_count, got.size_log2, got.dropped);
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.nearest_index !== want.nearest_index || got.color_count !== want.color_count ||
          got.size_log2 !== want.size_log2 || got.dropped !== want.dropped) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $write("result %0d mismatch: exp idx %0d count %0d size %0d drop %0b, ",
                 checked, want.nearest_index, want.color_count, want.size_log2,
                 want.dropped);
          $display("got idx %0d count %0d size %0d drop %0b",
                   got.nearest_index, got.color_count, got.size_log2, got.dropped);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pnct_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pnct_out_t out_data;

  palette_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  palette_nearest_color_table_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_beat(input logic [1:0] op, input logic [COLOR_W-1:0] rgb);
    pnct_in_t beat;
    int       gap;
    if (burst_left == 0) begin
      gap = 0;
      if ($urandom_range(0, 2) != 0)
        gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    beat.operation = op;
    beat.color = rgb;
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(beat);
  endtask

  function automatic logic [COLOR_W-1:0] known_color();
    return sb.colors[$urandom_range(0, int'(sb.used) - 1)];
  endfunction

  function automatic logic [COLOR_W-1:0] near_color(logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    int                 v;
    r = c;
    for (int ch = 0; ch < 3; ch++) begin
      v = int'(c[ch*8 +: 8]) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r[ch*8 +: 8] = 8'(v);
    end
    return r;
  endfunction

  // stimulus
  initial begin
    int                 pick;
    logic [COLOR_W-1:0] rgb;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused code, transparency alone and marked twice
    send_beat(OP_LOOKUP, 24'h123456);
    send_beat(OP_UNUSED, 24'hFFFFFF);
    send_beat(OP_TRANSPARENT, 24'h000000);
    send_beat(OP_LOOKUP, 24'h000000);
    send_beat(OP_TRANSPARENT, 24'hFFFFFF);
    send_beat(OP_APPEND, 24'hFFFFFF);
    send_beat(OP_APPEND, 24'h000000);
    send_beat(OP_APPEND, 24'hFF0000);
    send_beat(OP_APPEND, 24'h00FF00);
    send_beat(OP_APPEND, 24'h0000FF);
    send_beat(OP_APPEND, 24'h808080);
    send_beat(OP_APPEND, 24'h808080);
    // black must skip the transparent slot, ties go low
    send_beat(OP_LOOKUP, 24'h000000);
    send_beat(OP_LOOKUP, 24'hFFFFFF);
    send_beat(OP_LOOKUP, 24'h818181);
    send_beat(OP_LOOKUP, 24'h7F0000);
    send_beat(OP_LOOKUP, 24'hAAAAAA);
    send_beat(OP_LOOKUP, 24'h555555);
    send_beat(OP_UNUSED, 24'h000000);
    send_beat(OP_APPEND, 24'h404040);
    send_beat(OP_APPEND, 24'h404041);
    send_beat(OP_LOOKUP, 24'h404040);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        case ($urandom_range(0, 4))
          0: rgb = known_color();
          1: rgb = near_color(known_color());
          default: rgb = COLOR_W'($urandom);
        endcase
        send_beat(OP_APPEND, rgb);
      end else if (pick < 25) begin
        send_beat(OP_TRANSPARENT, COLOR_W'($urandom));
      end else if (pick < 28) begin
        send_beat(OP_UNUSED, COLOR_W'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: rgb = known_color();
          3, 4, 5: rgb = near_color(known_color());
          default: rgb = COLOR_W'($urandom);
        endcase
        send_beat(OP_LOOKUP, rgb);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (PAL_DEPTH + 8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // receiver stall patterns, one long hold to back up the cell row
  initial begin
    int mode;
    int seg;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(16, 160);
        for (int c = 0; c < seg; c++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 9) != 0);
            default: out_ready <= ((c % 7) < 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

endmodule
